[rtl/xrs_pkg.sv]
// xrs_pkg: shared types, operation codes and generator constants for the
// xorshift128+ random source. Depends on nothing.
package xrs_pkg;

  localparam logic [1:0] OP_RESEED = 2'd0;
  localparam logic [1:0] OP_RAW    = 2'd1;
  localparam logic [1:0] OP_RANGE  = 2'd2;
  localparam logic [1:0] OP_CHANCE = 2'd3;

  localparam logic [63:0] SEED_A_RESET = 64'h5ec50476f4102274;
  localparam logic [63:0] SEED_B_RESET = 64'ha50817f914a268a5;

  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 26;

  localparam int unsigned WARMUP_STEPS_DEFAULT = 16;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [30:0]        chance_denominator;
  } req_t;

  typedef struct packed {
    logic [63:0]        raw_sum;
    logic signed [31:0] range_value;
    logic               chance_hit;
  } rsp_t;

endpackage

[rtl/xorshift128plus_random_source_top.sv]
// xorshift128+ random source: raw values, integers in a range, one-in-N flags, and reseeding.
// flow: raw goes straight to the rsp register if the slot is free, else via finish;
// range and chance use the shared multiplier in the low and high multiply states, then
// finish; reseed steps the generator WARMUP_STEPS times, then finish; rsp stalls hold finish.
// Requests are taken only in idle: one raw beat per cycle while rsp is not stalled.
// reset: rst (synchronous) loads the fixed seed words, no response pending.
module xorshift128plus_random_source_top #(
  parameter int unsigned WARMUP_STEPS = xrs_pkg::WARMUP_STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  xrs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output xrs_pkg::rsp_t rsp
);

  // warm-up counter wide enough to hold WARMUP_STEPS itself
  localparam int unsigned CNT_W = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WARM   = 3'd1;
  localparam logic [2:0] ST_MUL_LO = 3'd2;
  localparam logic [2:0] ST_MUL_HI = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0]  state;
  logic [2:0]  state_next;

  // generator state words
  logic [63:0] word_a;
  logic [63:0] word_b;

  // per-beat working registers
  logic [1:0]        op;
  logic [63:0]       sum;
  logic [32:0]       span;
  logic [31:0]       low;
  logic [CNT_W-1:0]  count;

  // step unit
  logic [63:0] a_step;
  logic [63:0] b_step;
  logic [63:0] step_sum;
  logic        step_go;

  // multiplier
  logic        mul_en;
  logic [31:0] mul_a;
  logic [32:0] mul_addend;
  logic [64:0] mul_p;

  // request decode
  logic        req_fire;
  logic        rsp_free;
  logic        fast_raw;
  logic [32:0] diff;
  logic [32:0] range_span;
  logic [31:0] q;
  logic        fin_load;
  xrs_pkg::rsp_t fin_rsp;

  xrs_step u_step (
    .a      (word_a),
    .b      (word_b),
    .a_step (a_step),
    .b_step (b_step),
    .sum    (step_sum)
  );

  xrs_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (span),
    .addend (mul_addend),
    .p      (mul_p)
  );

  assign req_ready = (state == ST_IDLE);
  assign req_fire  = req_valid && req_ready;
  assign rsp_free  = !rsp_valid || rsp_ready;

  // a raw beat goes straight to the output register when the slot frees up
  assign fast_raw = req_fire && (req.operation == xrs_pkg::OP_RAW) && rsp_free;

  // generator advances on every non-reseed request and each warm-up cycle
  assign step_go = (req_fire && (req.operation != xrs_pkg::OP_RESEED)) ||
                   (state == ST_WARM);

  // span = high - low + 1, or zero for an inverted range
  always_comb begin
    diff       = {req.range_high[31], req.range_high} - {req.range_low[31], req.range_low};
    range_span = diff[32] ? 33'd0 : diff + 33'd1;
  end

  // low half first, then high half plus the carried upper bits of the low product
  assign mul_en     = (state == ST_MUL_LO) || (state == ST_MUL_HI);
  assign mul_a      = (state == ST_MUL_LO) ? sum[31:0] : sum[63:32];
  assign mul_addend = (state == ST_MUL_LO) ? 33'd0 : mul_p[64:32];

  // scaled integer: bits [63:32] of the combined product
  assign q = mul_p[63:32];

  always_comb begin
    fin_rsp = '0;
    case (op)
      xrs_pkg::OP_RESEED: begin
        fin_rsp = '0;
      end
      xrs_pkg::OP_RAW: begin
        fin_rsp.raw_sum = sum;
      end
      xrs_pkg::OP_RANGE: begin
        fin_rsp.raw_sum     = sum;
        fin_rsp.range_value = low + q;
      end
      xrs_pkg::OP_CHANCE: begin
        fin_rsp.raw_sum    = sum;
        fin_rsp.chance_hit = (q == 32'd0);
      end
      default: begin
        fin_rsp = '0;
      end
    endcase
  end

  assign fin_load = (state == ST_FIN) && rsp_free;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.operation)
            xrs_pkg::OP_RESEED: begin
              state_next = (WARMUP_STEPS == 0) ? ST_FIN : ST_WARM;
            end
            xrs_pkg::OP_RAW: begin
              state_next = fast_raw ? ST_IDLE : ST_FIN;
            end
            default: begin
              state_next = ST_MUL_LO;
            end
          endcase
        end
      end
      ST_WARM: begin
        if (count == CNT_W'(1)) begin
          state_next = ST_FIN;
        end
      end
      ST_MUL_LO: begin
        state_next = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      word_a <= xrs_pkg::SEED_A_RESET;
      word_b <= xrs_pkg::SEED_B_RESET;
      count  <= '0;
    end else begin
      state <= state_next;
      if (req_fire && (req.operation == xrs_pkg::OP_RESEED)) begin
        word_a <= req.seed_value;
        word_b <= 64'd0;
        count  <= CNT_W'(WARMUP_STEPS);
      end else if (step_go) begin
        word_a <= a_step;
        word_b <= b_step;
        if (state == ST_WARM) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op  <= req.operation;
      sum <= step_sum;
      low <= req.range_low;
      if (req.operation == xrs_pkg::OP_CHANCE) begin
        span <= {2'd0, req.chance_denominator};
      end else begin
        span <= range_span;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fast_raw || fin_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_raw) begin
      rsp.raw_sum     <= step_sum;
      rsp.range_value <= '0;
      rsp.chance_hit  <= 1'b0;
    end else if (fin_load) begin
      rsp <= fin_rsp;
    end
  end

endmodule

[rtl/xrs_step.sv]
// xrs_step: one xorshift128+ generator step, new state words and the sum.
// Depends on xrs_pkg for the shift amounts.
module xrs_step (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] a_step,
  output logic [63:0] b_step,
  output logic [63:0] sum
);

  logic [63:0] x1;
  logic [63:0] x2;

  always_comb begin
    x1     = a ^ (a << xrs_pkg::SHIFT_A);
    x2     = x1 ^ (x1 >> xrs_pkg::SHIFT_B);
    b_step = x2 ^ b ^ (b >> xrs_pkg::SHIFT_C);
    a_step = b;
    sum    = b_step + b;
  end

endmodule

[rtl/xrs_mul.sv]
// xrs_mul: shared 32 x 33 multiply-add with a registered 65-bit product.
// Used twice per scaling, for the low and high halves of the fraction.
// Depends on nothing.
module xrs_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [32:0] b,
  input  logic [32:0] addend,
  output logic [64:0] p
);

  logic [64:0] prod;

  always_comb begin
    prod = {33'd0, a} * {32'd0, b};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= prod + {32'd0, addend};
    end
  end

endmodule

[sim/xrs_checker.sv]
// xrs_checker: watches the request and response channels of the xorshift128+
// random source, predicts each response beat and compares it field by field.
// Depends on xrs_pkg for the beat types, operation codes and shift constants.
module xrs_checker #(
  parameter int unsigned WARMUP_STEPS = xrs_pkg::WARMUP_STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  xrs_pkg::req_t req,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  xrs_pkg::rsp_t rsp,
  output int            mismatches,
  output int            pending_beats
);

  logic [63:0]   gen_a;
  logic [63:0]   gen_b;
  xrs_pkg::rsp_t expected_beats[$];

  // one xorshift128+ step on the private state, returns the sum
  function automatic logic [63:0] advance_generator();
    logic [63:0] x;
    logic [63:0] y;
    x = gen_a;
    y = gen_b;
    gen_a = y;
    x = x ^ (x << xrs_pkg::SHIFT_A);
    x = x ^ (x >> xrs_pkg::SHIFT_B);
    x = x ^ y ^ (y >> xrs_pkg::SHIFT_C);
    gen_b = x;
    return x + y;
  endfunction

  // floor(frac * m / 2^64), m up to 2^32
  function automatic logic [32:0] frac_scale(logic [63:0] frac, logic [32:0] m);
    logic [96:0] prod;
    prod = {33'd0, frac} * {64'd0, m};
    return prod[96:64];
  endfunction

  function automatic xrs_pkg::rsp_t predict_beat(xrs_pkg::req_t r);
    xrs_pkg::rsp_t want;
    longint        lo;
    longint        hi;
    longint        d;
    logic [32:0]   span;
    logic [32:0]   q;
    want = '0;
    case (r.operation)
      xrs_pkg::OP_RESEED: begin
        gen_a = r.seed_value;
        gen_b = '0;
        repeat (WARMUP_STEPS) void'(advance_generator());
      end
      xrs_pkg::OP_RAW: begin
        want.raw_sum = advance_generator();
      end
      xrs_pkg::OP_RANGE: begin
        lo = $signed(r.range_low);
        hi = $signed(r.range_high);
        d  = hi - lo;
        // inverted range scales by zero and lands on range_low
        span = (d < 0) ? 33'd0 : 33'(d + 1);
        want.raw_sum     = advance_generator();
        q                = frac_scale(want.raw_sum, span);
        want.range_value = r.range_low + q[31:0];
      end
      default: begin
        want.raw_sum    = advance_generator();
        want.chance_hit = (frac_scale(want.raw_sum, {2'b00, r.chance_denominator}) == 33'd0);
      end
    endcase
    return want;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    xrs_pkg::rsp_t want;
    if (rst) begin
      gen_a = xrs_pkg::SEED_A_RESET;
      gen_b = xrs_pkg::SEED_B_RESET;
      expected_beats.delete();
    end else begin
      if (req_valid && req_ready) expected_beats.push_back(predict_beat(req));
      if (rsp_valid && rsp_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat raw_sum", rsp.raw_sum, 64'd0);
        end else begin
          want = expected_beats.pop_front();
          if (rsp.raw_sum !== want.raw_sum)
            report_mismatch("raw_sum", rsp.raw_sum, want.raw_sum);
          if (rsp.range_value !== want.range_value)
            report_mismatch("range_value", 64'(rsp.range_value), 64'(want.range_value));
          if (rsp.chance_hit !== want.chance_hit)
            report_mismatch("chance_hit", 64'(rsp.chance_hit), 64'(want.chance_hit));
        end
      end
    end
    pending_beats = expected_beats.size();
  end

endmodule

[sim/tb.sv]
// tb: stimulus and verdict for the xorshift128+ random source.
// Depends on xrs_pkg, xorshift128plus_random_source_top and xrs_checker.
module tb;

  localparam int unsigned WARMUP    = xrs_pkg::WARMUP_STEPS_DEFAULT;
  localparam int          N_RANDOM  = 1400;
  // longest quiet stretch of a correct run is about reseed latency plus a
  // full response stall plus a sender gap, well under this
  localparam int          IDLE_LIMIT = 400;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  xrs_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  xrs_pkg::rsp_t rsp;

  int   mismatches;
  int   pending_beats;
  int   idle_cycles;
  bit   req_calm;
  bit   rsp_calm;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xorshift128plus_random_source_top #(
    .WARMUP_STEPS(WARMUP)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  xrs_checker #(
    .WARMUP_STEPS(WARMUP)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_ready    (rsp_ready),
    .rsp          (rsp),
    .mismatches   (mismatches),
    .pending_beats(pending_beats)
  );

  // watchdog: too many cycles with no beat on either channel ends the run
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // response side: random stall before each beat, calm stretches in between
  initial begin
    int stall;
    rsp_ready = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
      stall = draw_gap(rsp_calm);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  // one request beat; valid only drops when a gap follows
  task automatic send_beat(logic [1:0] op, logic [63:0] seed, logic [31:0] lo,
                           logic [31:0] hi, logic [30:0] den);
    int gap;
    if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
    gap = draw_gap(req_calm);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{operation: op, seed_value: seed, range_low: lo, range_high: hi,
                   chance_denominator: den};
    do @(posedge clk); while (!req_ready);
  endtask

  // hold the sender until every predicted beat has drained; the count only
  // covers the last request beat from the following edge on
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
  endtask

  initial begin
    logic [1:0]  op;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] t;
    logic [30:0] den;
    int          w;
    int          k;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: steps from the reset state, then field extremes
    send_beat(xrs_pkg::OP_RAW, '0, '0, '0, '0);
    send_beat(xrs_pkg::OP_RAW, '1, '1, '1, '1);
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sh8000_0000, 32'sh7fff_ffff, '0);   // full range
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sh7fff_ffff, 32'sh8000_0000, '0);   // inverted
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sh7fff_ffff, 32'sh7fff_ffff, '0);   // single value top
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sh8000_0000, 32'sh8000_0000, '0);   // single value bottom
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sd0, 32'sd1, '0);
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sd5, -32'sd5, '0);                   // inverted, small
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'd0);                        // zero denominator
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'd1);
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'h7fff_ffff);
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'd2);
    // reseed with all-zero seed: the generator stays at zero afterwards
    send_beat(xrs_pkg::OP_RESEED, 64'd0, '1, '0, '1);
    send_beat(xrs_pkg::OP_RAW, '0, '0, '0, '0);
    send_beat(xrs_pkg::OP_RANGE, '0, 32'sh8000_0000, 32'sh7fff_ffff, '0);
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'h7fff_ffff);
    send_beat(xrs_pkg::OP_RESEED, '1, '0, '1, '0);
    send_beat(xrs_pkg::OP_RAW, '0, '0, '0, '0);
    send_beat(xrs_pkg::OP_RESEED, 64'h0000_0000_0000_0001, '0, '0, '0);
    send_beat(xrs_pkg::OP_RESEED, 64'h8000_0000_0000_0000, '0, '0, '0);    // back to back reseed
    send_beat(xrs_pkg::OP_RANGE, '0, -32'sd1, 32'sd0, '0);
    send_beat(xrs_pkg::OP_CHANCE, '0, '0, '0, 31'h4000_0000);
    drain_responses();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3 || i == 2 * N_RANDOM / 3 || $urandom_range(0, 199) == 0)
        drain_responses();
      w   = $urandom_range(0, 99);
      lo  = $urandom;
      hi  = $urandom;
      den = 31'($urandom);
      if (w < 8) begin
        op = xrs_pkg::OP_RESEED;
      end else if (w < 36) begin
        op = xrs_pkg::OP_RAW;
      end else if (w < 68) begin
        op = xrs_pkg::OP_RANGE;
        k  = $urandom_range(0, 9);
        case (k)
          0: begin
            lo = 32'h8000_0000;
            hi = 32'h7fff_ffff;
          end
          1, 2, 3: hi = lo + $urandom_range(0, 20);    // may wrap into an inverted range
          8: if ($signed(hi) > $signed(lo)) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
          9: hi = lo;
          default: if ($signed(hi) < $signed(lo)) begin
            t  = lo;
            lo = hi;
            hi = t;
          end
        endcase
      end else begin
        op = xrs_pkg::OP_CHANCE;
        k  = $urandom_range(0, 15);
        case (k)
          0: den = 31'd0;
          1: den = 31'd1;
          2: den = 31'h7fff_ffff;
          3, 4, 5, 6: den = 31'($urandom_range(2, 10));
          default: ;
        endcase
      end
      send_beat(op, rand64(), lo, hi, den);
    end

    drain_responses();
    // let any late or stray beat show up before the verdict
    repeat (WARMUP + 24) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
